@@ sv/datetime_text_validator_top_defines.svh @@
// Assertion macros shared by the timestamp checker modules.
`ifndef DATETIME_TEXT_VALIDATOR_TOP_DEFINES_SVH
`define DATETIME_TEXT_VALIDATOR_TOP_DEFINES_SVH

// Check that cond holds in the same cycle as trig.
`define DTV_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("dtv assertion failed");

// Check that cond holds in the cycle after trig.
`define DTV_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("dtv assertion failed");

`endif

@@ sv/dtv_pkg.sv @@
// Package: constants, types and helper functions of the timestamp checker.
`default_nettype none
package dtv_pkg;

   localparam int unsigned POS_W   = 5;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned FIELD_W = 7;
   localparam int unsigned MS_W    = 17;

   localparam logic [POS_W-1:0] TEMPLATE_LEN = 5'd23;
   localparam logic [POS_W-1:0] POS_SAT      = 5'd24;
   localparam logic [POS_W-1:0] MIN_COMPLETE = 5'd16;
   localparam logic [POS_W-1:0] MIN_SECONDS  = 5'd19;

   localparam logic [POS_W-1:0] POS_DATE_SEP1 = 5'd4;
   localparam logic [POS_W-1:0] POS_MONTH_END = 5'd7;
   localparam logic [POS_W-1:0] POS_DATE_TIME = 5'd10;
   localparam logic [POS_W-1:0] POS_HOUR_END  = 5'd13;
   localparam logic [POS_W-1:0] POS_MIN_END   = 5'd16;
   localparam logic [POS_W-1:0] POS_SEC_TENS  = 5'd17;
   localparam logic [POS_W-1:0] POS_SEC_UNITS = 5'd18;
   localparam logic [POS_W-1:0] POS_DOT       = 5'd19;
   localparam logic [POS_W-1:0] POS_FRAC1     = 5'd20;
   localparam logic [POS_W-1:0] POS_FRAC2     = 5'd21;
   localparam logic [POS_W-1:0] POS_CENTURY   = 5'd2;
   localparam logic [POS_W-1:0] POS_YEAR_LOW  = 5'd3;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_T     = 8'h54;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   localparam logic [FIELD_W-1:0] MAX_MONTH  = 7'd12;
   localparam logic [FIELD_W-1:0] MAX_HOUR   = 7'd23;
   localparam logic [FIELD_W-1:0] MAX_MINUTE = 7'd59;
   localparam logic [MS_W-1:0]    MAX_MILLIS = 17'd60000;

   localparam logic [FIELD_W-1:0] MONTH_FEB = 7'd2;
   localparam logic [FIELD_W-1:0] MONTH_APR = 7'd4;
   localparam logic [FIELD_W-1:0] MONTH_JUN = 7'd6;
   localparam logic [FIELD_W-1:0] MONTH_SEP = 7'd9;
   localparam logic [FIELD_W-1:0] MONTH_NOV = 7'd11;

   typedef enum logic [1:0] {
      QUAL_SYNTAX     = 2'd0,
      QUAL_INCOMPLETE = 2'd1,
      QUAL_IMPROPER   = 2'd2,
      QUAL_GOOD       = 2'd3
   } quality_type;

   // Parse summary handed from the scanner to the range checker.
   typedef struct packed {
      logic               bad;
      logic               complete;
      logic               has_secs;
      logic               leap;
      logic [YEAR_W-1:0]  year;
      logic [FIELD_W-1:0] month;
      logic [FIELD_W-1:0] day;
      logic [FIELD_W-1:0] hour;
      logic [FIELD_W-1:0] minute;
      logic [MS_W-1:0]    millis;
   } snap_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic slot_matches(input logic [POS_W-1:0] p, input logic [7:0] c);
      logic ok;
      case (p)
         POS_DATE_SEP1, POS_MONTH_END: ok = (c == CHAR_SLASH) || (c == CHAR_DASH);
         POS_DATE_TIME: ok = (c == CHAR_SPACE) || (c == CHAR_SLASH) || (c == CHAR_T);
         POS_HOUR_END, POS_MIN_END: ok = (c == CHAR_COLON);
         POS_DOT: ok = (c == CHAR_DOT);
         default: ok = is_digit(c);
      endcase
      return ok;
   endfunction

   // Weight of a seconds digit in milliseconds.
   function automatic logic [MS_W-1:0] digit_weight(input logic [POS_W-1:0] p);
      logic [MS_W-1:0] w;
      case (p)
         POS_SEC_TENS:  w = 17'd10000;
         POS_SEC_UNITS: w = 17'd1000;
         POS_FRAC1:     w = 17'd100;
         POS_FRAC2:     w = 17'd10;
         default:       w = 17'd1;
      endcase
      return w;
   endfunction

   function automatic logic [4:0] month_days(input logic [FIELD_W-1:0] m, input logic leap);
      logic [4:0] n;
      case (m)
         MONTH_FEB: n = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = 5'd30;
         default: n = 5'd31;
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

@@ sv/dtv_req_if.sv @@
// Interface: character channel into the timestamp checker.
`default_nettype none
interface dtv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       char_present;
   logic       last;

   modport source (output valid, char_code, char_present, last, input ready);
   modport sink (input valid, char_code, char_present, last, output ready);
endinterface
`default_nettype wire

@@ sv/dtv_rsp_if.sv @@
// Interface: result channel out of the timestamp checker.
`default_nettype none
interface dtv_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  quality;
   logic [13:0] year;
   logic [6:0]  month;
   logic [6:0]  day;
   logic [6:0]  hour;
   logic [6:0]  minute;
   logic [16:0] millis;

   modport source (output valid, quality, year, month, day, hour, minute, millis,
                   input ready);
   modport sink (input valid, quality, year, month, day, hour, minute, millis,
                 output ready);
endinterface
`default_nettype wire

@@ sv/dtv_scan.sv @@
// Module: input register, template match and digit accumulation.
`default_nettype none
`include "datetime_text_validator_top_defines.svh"
module dtv_scan (
   input  wire logic             clock,
   input  wire logic             reset,
   dtv_req_if.sink               req,
   output dtv_pkg::snap_type     snap,
   output logic                  snap_valid,
   input  wire logic             snap_ready
);
   import dtv_pkg::*;

   logic                in_valid_ff;
   logic [7:0]          in_char_ff;
   logic                in_present_ff;
   logic                in_last_ff;

   logic [POS_W-1:0]    pos_ff, pos_in;
   logic                bad_ff, bad_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [FIELD_W-1:0]  month_ff, month_in;
   logic [FIELD_W-1:0]  day_ff, day_in;
   logic [FIELD_W-1:0]  hour_ff, hour_in;
   logic [FIELD_W-1:0]  minute_ff, minute_in;
   logic [MS_W-1:0]     millis_ff, millis_in;
   logic [1:0]          cent_ff, cent_in;
   logic                tail_ff, tail_in;

   snap_type            snap_ff, snap_in;
   logic                snap_valid_ff;
   logic                advance;
   logic [3:0]          digit;

   // Move the held item on unless it ends a text and the summary slot is full and not being taken.
   assign advance   = in_valid_ff && (!in_last_ff || !snap_valid_ff || snap_ready);
   assign req.ready = !in_valid_ff || advance;

   assign snap       = snap_ff;
   assign snap_valid = snap_valid_ff;

   always_comb begin
      pos_in    = pos_ff;
      bad_in    = bad_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      millis_in = millis_ff;
      cent_in   = cent_ff;
      tail_in   = tail_ff;
      digit     = 4'(in_char_ff - CHAR_ZERO);
      if (in_present_ff) begin
         if (pos_ff >= TEMPLATE_LEN || !slot_matches(pos_ff, in_char_ff)) begin
            bad_in = 1'b1;
         end else if (is_digit(in_char_ff)) begin
            if (pos_ff < POS_DATE_SEP1) begin
               year_in = 14'(year_ff * 14'd10 + 14'(digit));
               // century mod 4 and trailing zeros give the leap rule without a divider
               if (pos_ff < POS_CENTURY) begin
                  cent_in = 2'({cent_ff[0], 1'b0} + digit[1:0]);
               end else if (pos_ff == POS_CENTURY) begin
                  tail_in = (digit == 4'd0);
               end else begin
                  tail_in = tail_ff && (digit == 4'd0);
               end
            end else if (pos_ff < POS_MONTH_END) begin
               month_in = 7'(month_ff * 7'd10 + 7'(digit));
            end else if (pos_ff < POS_DATE_TIME) begin
               day_in = 7'(day_ff * 7'd10 + 7'(digit));
            end else if (pos_ff < POS_HOUR_END) begin
               hour_in = 7'(hour_ff * 7'd10 + 7'(digit));
            end else if (pos_ff < POS_MIN_END) begin
               minute_in = 7'(minute_ff * 7'd10 + 7'(digit));
            end else begin
               millis_in = 17'(millis_ff + 17'(digit) * digit_weight(pos_ff));
            end
         end
         if (pos_ff < POS_SAT) begin
            pos_in = 5'(pos_ff + 5'd1);
         end
      end

      snap_in.bad      = bad_in;
      snap_in.complete = (pos_in >= MIN_COMPLETE);
      snap_in.has_secs = (pos_in >= MIN_SECONDS);
      snap_in.leap     = (year_in[1:0] == 2'd0) && (!tail_in || cent_in == 2'd0);
      snap_in.year     = year_in;
      snap_in.month    = month_in;
      snap_in.day      = day_in;
      snap_in.hour     = hour_in;
      snap_in.minute   = minute_in;
      snap_in.millis   = (pos_in >= MIN_SECONDS) ? millis_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         snap_valid_ff <= 1'b0;
         pos_ff        <= '0;
         bad_ff        <= 1'b0;
         year_ff       <= '0;
         month_ff      <= '0;
         day_ff        <= '0;
         hour_ff       <= '0;
         minute_ff     <= '0;
         millis_ff     <= '0;
         cent_ff       <= '0;
         tail_ff       <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (snap_ready) begin
            snap_valid_ff <= 1'b0;
         end
         if (advance) begin
            if (in_last_ff) begin
               snap_valid_ff <= 1'b1;
               pos_ff        <= '0;
               bad_ff        <= 1'b0;
               year_ff       <= '0;
               month_ff      <= '0;
               day_ff        <= '0;
               hour_ff       <= '0;
               minute_ff     <= '0;
               millis_ff     <= '0;
               cent_ff       <= '0;
               tail_ff       <= 1'b0;
            end else begin
               pos_ff    <= pos_in;
               bad_ff    <= bad_in;
               year_ff   <= year_in;
               month_ff  <= month_in;
               day_ff    <= day_in;
               hour_ff   <= hour_in;
               minute_ff <= minute_in;
               millis_ff <= millis_in;
               cent_ff   <= cent_in;
               tail_ff   <= tail_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready) begin
         in_char_ff    <= req.char_code;
         in_present_ff <= req.char_present;
         in_last_ff    <= req.last;
      end
      if (advance && in_last_ff) begin
         snap_ff <= snap_in;
      end
   end

   `DTV_ASSERT_SAME(a_pos_saturates, clock, reset, 1'b1, pos_ff <= POS_SAT)
   `DTV_ASSERT_NEXT(a_clear_after_end, clock, reset, advance && in_last_ff, pos_ff == '0 && !bad_ff && millis_ff == '0)
   `DTV_ASSERT_SAME(a_secs_gated, clock, reset, snap_valid_ff && !snap_ff.has_secs, snap_ff.millis == '0)

endmodule
`default_nettype wire

@@ sv/dtv_check.sv @@
// Module: range check of a parsed timestamp and the result register.
`default_nettype none
`include "datetime_text_validator_top_defines.svh"
module dtv_check (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dtv_pkg::snap_type snap,
   input  wire logic             snap_valid,
   output logic                  snap_ready,
   dtv_rsp_if.source             rsp
);
   import dtv_pkg::*;

   logic                rsp_valid_ff;
   quality_type         quality_ff, quality_in;
   logic [YEAR_W-1:0]   year_ff, year_in;
   logic [FIELD_W-1:0]  month_ff, month_in;
   logic [FIELD_W-1:0]  day_ff, day_in;
   logic [FIELD_W-1:0]  hour_ff, hour_in;
   logic [FIELD_W-1:0]  minute_ff, minute_in;
   logic [MS_W-1:0]     millis_ff, millis_in;
   logic                improper;

   assign snap_ready = !rsp_valid_ff || rsp.ready;

   always_comb begin
      improper = (snap.month == '0) || (snap.month > MAX_MONTH) ||
                 (snap.day > {2'b00, month_days(snap.month, snap.leap)}) ||
                 (snap.hour > MAX_HOUR) || (snap.minute > MAX_MINUTE) ||
                 (snap.millis > MAX_MILLIS);
      if (snap.bad) begin
         quality_in = QUAL_SYNTAX;
      end else if (!snap.complete) begin
         quality_in = QUAL_INCOMPLETE;
      end else if (improper) begin
         quality_in = QUAL_IMPROPER;
      end else begin
         quality_in = QUAL_GOOD;
      end
      // drop the fields of a text that did not parse
      if (quality_in == QUAL_SYNTAX || quality_in == QUAL_INCOMPLETE) begin
         year_in   = '0;
         month_in  = '0;
         day_in    = '0;
         hour_in   = '0;
         minute_in = '0;
         millis_in = '0;
      end else begin
         year_in   = snap.year;
         month_in  = snap.month;
         day_in    = snap.day;
         hour_in   = snap.hour;
         minute_in = snap.minute;
         millis_in = snap.millis;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         rsp_valid_ff <= snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (snap_ready && snap_valid) begin
         quality_ff <= quality_in;
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         millis_ff  <= millis_in;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.quality = quality_ff;
   assign rsp.year    = year_ff;
   assign rsp.month   = month_ff;
   assign rsp.day     = day_ff;
   assign rsp.hour    = hour_ff;
   assign rsp.minute  = minute_ff;
   assign rsp.millis  = millis_ff;

   `DTV_ASSERT_SAME(a_unparsed_zero, clock, reset, rsp_valid_ff && (quality_ff == QUAL_SYNTAX || quality_ff == QUAL_INCOMPLETE), year_ff == '0 && month_ff == '0 && millis_ff == '0)
   `DTV_ASSERT_SAME(a_good_in_range, clock, reset, rsp_valid_ff && quality_ff == QUAL_GOOD, month_ff != '0 && month_ff <= MAX_MONTH && hour_ff <= MAX_HOUR && millis_ff <= MAX_MILLIS)
   `DTV_ASSERT_NEXT(a_take_gives_result, clock, reset, snap_valid && snap_ready, rsp_valid_ff)

endmodule
`default_nettype wire

@@ sv/datetime_text_validator_top.sv @@
// Top level: timestamp text checker, one character item in per cycle while the result side does not stall.
// A text's end item goes from the input register to the summary register and then to the result register.
// Throughput: one character item per cycle, with results back to back, while the result side keeps taking them.
// The input register, the summary register and the result register each hold one item.
// Synchronous reset clears the pipeline valids and all parse state; no item is lost
// or repeated under stalls on either side.
`default_nettype none
module datetime_text_validator_top (
   input  wire logic clock,
   input  wire logic reset,
   dtv_req_if.sink   req,
   dtv_rsp_if.source rsp
);
   import dtv_pkg::*;

   // Parse summary of a finished text, held between scanner and checker.
   snap_type snap;
   logic     snap_valid;
   logic     snap_ready;

   // Scanner: register each character item, match it against the template slot
   // for its position and accumulate the digits; on the end item, hand over a
   // summary and clear the parse state for the next text.
   dtv_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .snap       (snap),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready)
   );

   // Checker: grade the summary (syntax, completeness, field ranges including
   // the Gregorian month length) and hold the result item until it is taken.
   dtv_check u_check (
      .clock      (clock),
      .reset      (reset),
      .snap       (snap),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .rsp        (rsp)
   );

endmodule
`default_nettype wire

@@ bench/timestamp_result_checker.sv @@
// Checker: follows texts on the character channel, predicts each result and scores it.
`timescale 1ns / 1ps
`default_nettype none
module timestamp_result_checker (
   input  wire logic clock,
   input  wire logic reset,
   dtv_req_if        req,
   dtv_rsp_if        rsp,
   output int        fault_count,
   output int        awaited
);

   // Template slots of yyyy/mm/dd&hh:mm:ss.fff
   localparam logic [4:0] AT_DATE_SEP_A = 5'd4;
   localparam logic [4:0] AT_DATE_SEP_B = 5'd7;
   localparam logic [4:0] AT_DATE_TIME  = 5'd10;
   localparam logic [4:0] AT_HM_SEP     = 5'd13;
   localparam logic [4:0] AT_MS_SEP     = 5'd16;
   localparam logic [4:0] AT_SEC_TENS   = 5'd17;
   localparam logic [4:0] AT_SEC_UNITS  = 5'd18;
   localparam logic [4:0] AT_DOT        = 5'd19;
   localparam logic [4:0] AT_FRAC_A     = 5'd20;
   localparam logic [4:0] AT_FRAC_B     = 5'd21;
   localparam logic [4:0] SLOT_COUNT    = 5'd23;
   localparam logic [4:0] SLOT_SAT      = 5'd24;
   localparam logic [4:0] FULL_DATE_TIME = 5'd16;
   localparam logic [4:0] WITH_SECONDS  = 5'd19;

   localparam int unsigned LAST_MONTH  = 12;
   localparam int unsigned LAST_HOUR   = 23;
   localparam int unsigned LAST_MINUTE = 59;
   localparam int unsigned MILLIS_CAP  = 60000;
   localparam int          LOUD_FAULTS = 10;

   typedef struct packed {
      dtv_pkg::quality_type quality;
      logic [13:0]          year;
      logic [6:0]           month;
      logic [6:0]           day;
      logic [6:0]           hour;
      logic [6:0]           minute;
      logic [16:0]          millis;
   } stamp_result_type;

   stamp_result_type expected_stamps[$];

   logic [4:0]  scan_pos;
   logic        scan_bad;
   logic [13:0] year_sum;
   logic [6:0]  month_sum;
   logic [6:0]  day_sum;
   logic [6:0]  hour_sum;
   logic [6:0]  minute_sum;
   logic [16:0] ms_sum;
   int          faults = 0;

   assign fault_count = faults;

   function automatic void clear_scan();
      scan_pos   = '0;
      scan_bad   = 1'b0;
      year_sum   = '0;
      month_sum  = '0;
      day_sum    = '0;
      hour_sum   = '0;
      minute_sum = '0;
      ms_sum     = '0;
   endfunction

   function automatic logic slot_fits(input logic [4:0] p, input logic [7:0] c);
      case (p)
         AT_DATE_SEP_A, AT_DATE_SEP_B: return c == "/" || c == "-";
         AT_DATE_TIME:                 return c == " " || c == "/" || c == "T";
         AT_HM_SEP, AT_MS_SEP:         return c == ":";
         AT_DOT:                       return c == ".";
         default:                      return c >= "0" && c <= "9";
      endcase
   endfunction

   function automatic void absorb_char(input logic [7:0] c);
      logic [3:0] d;
      d = c[3:0];
      if (scan_pos >= SLOT_COUNT || !slot_fits(scan_pos, c)) begin
         scan_bad = 1'b1;
      end else if (c >= "0" && c <= "9") begin
         if (scan_pos < AT_DATE_SEP_A) year_sum = 14'(year_sum * 14'd10 + 14'(d));
         else if (scan_pos < AT_DATE_SEP_B) month_sum = 7'(month_sum * 7'd10 + 7'(d));
         else if (scan_pos < AT_DATE_TIME) day_sum = 7'(day_sum * 7'd10 + 7'(d));
         else if (scan_pos < AT_HM_SEP) hour_sum = 7'(hour_sum * 7'd10 + 7'(d));
         else if (scan_pos < AT_MS_SEP) minute_sum = 7'(minute_sum * 7'd10 + 7'(d));
         else begin
            case (scan_pos)
               AT_SEC_TENS:  ms_sum = 17'(ms_sum + 17'(d) * 17'd10000);
               AT_SEC_UNITS: ms_sum = 17'(ms_sum + 17'(d) * 17'd1000);
               AT_FRAC_A:    ms_sum = 17'(ms_sum + 17'(d) * 17'd100);
               AT_FRAC_B:    ms_sum = 17'(ms_sum + 17'(d) * 17'd10);
               default:      ms_sum = 17'(ms_sum + 17'(d));
            endcase
         end
      end
      if (scan_pos < SLOT_SAT) scan_pos = 5'(scan_pos + 5'd1);
   endfunction

   // Grade the text gathered so far, then start afresh.
   function automatic stamp_result_type close_text();
      stamp_result_type r;
      logic [16:0]      ms;
      logic             leap;
      int unsigned      month_len;
      ms   = (scan_pos >= WITH_SECONDS) ? ms_sum : '0;
      leap = (year_sum % 4 == 0) && ((year_sum % 100 != 0) || (year_sum % 400 == 0));
      case (month_sum)
         7'd2:                    month_len = leap ? 29 : 28;
         7'd4, 7'd6, 7'd9, 7'd11: month_len = 30;
         default:                 month_len = 31;
      endcase
      r = '0;
      if (scan_bad) begin
         r.quality = dtv_pkg::QUAL_SYNTAX;
      end else if (scan_pos < FULL_DATE_TIME) begin
         r.quality = dtv_pkg::QUAL_INCOMPLETE;
      end else begin
         r.year   = year_sum;
         r.month  = month_sum;
         r.day    = day_sum;
         r.hour   = hour_sum;
         r.minute = minute_sum;
         r.millis = ms;
         if (month_sum < 1 || month_sum > LAST_MONTH || day_sum > month_len ||
             hour_sum > LAST_HOUR || minute_sum > LAST_MINUTE || ms > MILLIS_CAP)
            r.quality = dtv_pkg::QUAL_IMPROPER;
         else
            r.quality = dtv_pkg::QUAL_GOOD;
      end
      clear_scan();
      return r;
   endfunction

   always @(posedge clock) begin
      stamp_result_type want;
      stamp_result_type got;
      if (reset) begin
         clear_scan();
         expected_stamps.delete();
         awaited <= 0;
      end else begin
         if (req.valid && req.ready) begin
            if (req.char_present) absorb_char(req.char_code);
            if (req.last) expected_stamps.push_back(close_text());
         end
         if (rsp.valid && rsp.ready) begin
            got = '{dtv_pkg::quality_type'(rsp.quality), rsp.year, rsp.month, rsp.day,
                    rsp.hour, rsp.minute, rsp.millis};
            if (expected_stamps.size() == 0) begin
               if (faults < LOUD_FAULTS)
                  $display("%0t: unexpected result q=%0d %0d/%0d/%0d %0d:%0d ms=%0d",
                           $realtime, got.quality, got.year, got.month, got.day,
                           got.hour, got.minute, got.millis);
               faults++;
            end else begin
               want = expected_stamps.pop_front();
               if (got !== want) begin
                  if (faults < LOUD_FAULTS) begin
                     $display("%0t: result mismatch, expected q=%0d %0d/%0d/%0d %0d:%0d ms=%0d",
                              $realtime, want.quality, want.year, want.month, want.day,
                              want.hour, want.minute, want.millis);
                     $display("%0t:                  got      q=%0d %0d/%0d/%0d %0d:%0d ms=%0d",
                              $realtime, got.quality, got.year, got.month, got.day,
                              got.hour, got.minute, got.millis);
                  end
                  faults++;
               end
            end
         end
         awaited <= expected_stamps.size();
      end
   end

endmodule
`default_nettype wire

@@ bench/datetime_text_validator_top_tb.sv @@
// Testbench top: drives timestamp texts into the checker block and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module datetime_text_validator_top_tb;

   localparam int PERIOD       = 8;
   localparam int RESET_CYCLES = 9;
   localparam int STALL_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int ITEM_TARGET  = 450;   // items for the whole run, directed texts included
   localparam int CALM_ITEMS   = 20;    // closing stretch with no idling at all
   localparam int SETTLE       = 8;

   logic       clock = 1'b0;
   logic       reset;
   bit         idle_on;
   int         faults;
   int         awaited;
   int         sent_items;
   int         quiet_cycles;
   logic [7:0] stamp_chars[$];

   dtv_req_if req_ch();
   dtv_rsp_if rsp_ch();

   datetime_text_validator_top dut (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch)
   );

   timestamp_result_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fault_count(faults),
      .awaited    (awaited)
   );

   always #(PERIOD / 2) clock = ~clock;

   // Watchdog: end the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT - 1) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: drop ready in random bursts while idling is allowed, else hold it high.
   initial begin
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one item and hold it until accepted; called and returns at a falling edge.
   task automatic send_byte(input logic [7:0] c, input logic present, input logic ends);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.char_code    <= c;
      req_ch.char_present <= present;
      req_ch.last         <= ends;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      // empty non-final items are ignored by the block; leave them out of the tally
      if (present || ends) sent_items++;
   endtask

   // Send the buffered text, with stray empty items sprinkled in. The end goes either
   // with the final character or as an empty item of its own.
   task automatic send_stamp(input bit split_end);
      for (int i = 0; i < stamp_chars.size(); i++) begin
         if ($urandom_range(0, 15) == 0) send_byte(8'($urandom), 1'b0, 1'b0);
         send_byte(stamp_chars[i], 1'b1, !split_end && i == stamp_chars.size() - 1);
      end
      if (split_end || stamp_chars.size() == 0) send_byte(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic send_text(input string s, input bit split_end);
      stamp_chars.delete();
      foreach (s[i]) stamp_chars.push_back(s[i]);
      send_stamp(split_end);
   endtask

   // Hold the sender until every result owed has come out.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (awaited != 0) @(negedge clock);
   endtask

   function automatic int unsigned pick_value(input int unsigned a, b, c, lo, hi);
      case ($urandom_range(0, 5))
         0:       return a;
         1:       return b;
         2:       return c;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   function automatic void put_number(input int unsigned v, input int unsigned n);
      int unsigned scale = 1;
      repeat (n - 1) scale *= 10;
      repeat (n) begin
         stamp_chars.push_back(8'("0" + (v / scale) % 10));
         scale /= 10;
      end
   endfunction

   // Build a well-formed timestamp with values leaning on the range edges, then
   // sometimes cut it short, run it long or spoil one character.
   function automatic void build_stamp();
      int unsigned year_v, month_v, day_v, hour_v, minute_v, ms_v;
      int unsigned keep;
      year_v   = pick_value(2000, 1900, 9999 * $urandom_range(0, 1), 0, 9999);
      month_v  = ($urandom_range(0, 3) != 0) ? $urandom_range(12, 1)
                                             : pick_value(0, 13, 99, 0, 99);
      day_v    = ($urandom_range(0, 7) == 0) ? $urandom_range(99, 0)
                                             : pick_value(28, 29, 31, 0, 31);
      hour_v   = ($urandom_range(0, 5) == 0) ? pick_value(23, 24, 99, 0, 99)
                                             : $urandom_range(23, 0);
      minute_v = ($urandom_range(0, 5) == 0) ? pick_value(59, 60, 99, 0, 99)
                                             : $urandom_range(59, 0);
      ms_v     = ($urandom_range(0, 5) == 0) ? pick_value(60000, 60001, 99999, 0, 99999)
                                             : $urandom_range(59999, 0);
      stamp_chars.delete();
      put_number(year_v, 4);
      stamp_chars.push_back($urandom_range(0, 1) ? "/" : "-");
      put_number(month_v, 2);
      stamp_chars.push_back($urandom_range(0, 1) ? "/" : "-");
      put_number(day_v, 2);
      case ($urandom_range(0, 2))
         0:       stamp_chars.push_back(" ");
         1:       stamp_chars.push_back("/");
         default: stamp_chars.push_back("T");
      endcase
      put_number(hour_v, 2);
      stamp_chars.push_back(":");
      put_number(minute_v, 2);
      stamp_chars.push_back(":");
      put_number(ms_v / 1000, 2);
      stamp_chars.push_back(".");
      put_number(ms_v % 1000, 3);
      case ($urandom_range(0, 11))
         9:  keep = $urandom_range(22, 0);
         10: keep = $urandom_range(22, 16);
         11: begin
            keep = stamp_chars.size();
            repeat ($urandom_range(1, 3)) stamp_chars.push_back(8'($urandom));
         end
         default: keep = stamp_chars.size();
      endcase
      while (stamp_chars.size() > keep) void'(stamp_chars.pop_back());
      if (stamp_chars.size() > 0 && $urandom_range(0, 7) == 0)
         stamp_chars[$urandom_range(stamp_chars.size() - 1, 0)] = 8'($urandom);
   endfunction

   initial begin
      reset               = 1'b1;
      idle_on             = 1'b0;
      sent_items          = 0;
      req_ch.valid        = 1'b0;
      req_ch.char_code    = 8'h00;
      req_ch.char_present = 1'b0;
      req_ch.last         = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed texts: leap rules, range edges, partial seconds, bad syntax.
      send_text("2024/02/29 23:59:59.999", 1'b0);
      send_text("1900-02-29T00:00:00.000", 1'b1);
      send_text("2000/02/29/12:30:60.000", 1'b0);
      send_text("0000-01-00T00:00:60.001", 1'b0);
      send_text("9999/12/31 23:59:59.999", 1'b1);
      idle_on = 1'b1;
      send_text("9999/99/99T99:99:99.999", 1'b0);
      send_text("0000/00/00 00:00", 1'b0);
      send_text("2023/04/31 12:00:0", 1'b1);
      send_text("2023-06-30 24:00:00", 1'b0);
      send_text("2023/11/30T00:60:00.", 1'b0);
      send_text("2023/09/15 10:20:30.1", 1'b0);
      send_text("2023/09/15 10:20:30.12", 1'b1);
      // one character past the template
      send_text("2023/09/15 10:20:30.1234", 1'b0);
      // empty text, then two short ones
      send_text("", 1'b1);
      send_text("2023/09/1", 1'b0);
      send_text("2023/09/15 10:2", 1'b0);
      send_text("2023.09.15 10:20:30.000", 1'b0);
      send_text("2023/09/15X10:20:30.000", 1'b0);
      // a zero character at the front, preceded by an ignored empty item
      send_byte(8'hA5, 1'b0, 1'b0);
      send_byte(8'h00, 1'b1, 1'b0);
      send_text("2023/01/01 00:00:00.000", 1'b0);
      send_byte(8'hFF, 1'b1, 1'b1);
      send_text("2023/02/28 00:00:59.999", 1'b1);
      drain_results();

      // Random texts until the item budget is spent; the closing stretch runs with
      // no idling on either side.
      while (sent_items < ITEM_TARGET) begin
         idle_on = (sent_items < ITEM_TARGET - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
         build_stamp();
         send_stamp($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 24) == 0) drain_results();
      end
      idle_on = 1'b0;
      req_ch.valid <= 1'b0;

      // Let the last results out, then allow a few cycles for strays.
      while (awaited != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
      if (faults == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
